// File: rtl/mu2a_pkg.sv
package mu2a_pkg;

    localparam int LA_DEPTH = 6;

    // Lead and tag bytes and masks of the modified UTF-8 forms, reset replacement byte and error data byte
    localparam logic [7:0] SURR_LEAD     = 8'hED;
    localparam logic [7:0] SURR_HI_TAG   = 8'hA0;
    localparam logic [7:0] SURR_LO_TAG   = 8'hB0;
    localparam logic [7:0] CONT_TAG      = 8'h80;
    localparam logic [7:0] CONT_MASK     = 8'hC0;
    localparam logic [7:0] TWO_TAG       = 8'hC0;
    localparam logic [7:0] TWO_MASK      = 8'hE0;
    localparam logic [7:0] THREE_TAG     = 8'hE0;
    localparam logic [7:0] NIBBLE_MASK   = 8'hF0;
    localparam logic [7:0] REPL_RESET    = 8'h3F;
    localparam logic [7:0] ERR_CHAR      = 8'h00;

    typedef logic [2:0] cnt_t;
    typedef logic [LA_DEPTH-1:0][7:0] la_buf_t;

    typedef enum logic [2:0] {
        CLS_WAIT,
        CLS_ONE,
        CLS_TWO,
        CLS_THREE,
        CLS_SIX,
        CLS_ERR
    } cls_t;

    // What the lookahead offers at its head this cycle
    typedef struct packed {
        cls_t       cls;
        logic [7:0] head_byte;
        logic       drains;
        logic       at_end;
    } head_t;

    function automatic logic is_cont(logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    function automatic cls_t classify(la_buf_t b, cnt_t n, logic at_end);
        cls_t res;
        logic sur_ok;
        logic tri_ok;
        sur_ok = (b[0] == SURR_LEAD)
            && (n < 3'd2 || (b[1] & NIBBLE_MASK) == SURR_HI_TAG)
            && (n < 3'd3 || is_cont(b[2]))
            && (n < 3'd4 || b[3] == SURR_LEAD)
            && (n < 3'd5 || (b[4] & NIBBLE_MASK) == SURR_LO_TAG)
            && (n < 3'd6 || is_cont(b[5]));
        tri_ok = ((b[0] & NIBBLE_MASK) == THREE_TAG)
            && (n < 3'd2 || is_cont(b[1]))
            && (n < 3'd3 || is_cont(b[2]));
        priority if (n == 3'd0)
            res = CLS_WAIT;
        else if (!b[0][7])
            res = CLS_ONE;
        else if (sur_ok && n >= 3'd6)
            res = CLS_SIX;
        else if (sur_ok && !at_end)
            res = CLS_WAIT;
        else if (tri_ok && n >= 3'd3)
            res = CLS_THREE;
        else if (tri_ok && !at_end)
            res = CLS_WAIT;
        else if ((b[0] & TWO_MASK) == TWO_TAG)
        begin
            if (n >= 3'd2)
                res = is_cont(b[1]) ? CLS_TWO : CLS_ERR;
            else
                res = at_end ? CLS_ERR : CLS_WAIT;
        end
        else
            res = CLS_ERR;
        return res;
    endfunction

    function automatic cnt_t cls_size(cls_t c);
        cnt_t s;
        unique case (c)
            CLS_ONE:   s = 3'd1;
            CLS_TWO:   s = 3'd2;
            CLS_THREE: s = 3'd3;
            CLS_SIX:   s = 3'd6;
            default:   s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/modified_utf8_to_ascii.sv
// Decodes a Java modified UTF-8 string, one byte per transaction with tlast on
// the final byte, into one result per character: ASCII bytes pass through and
// every multibyte character (two-byte, three-byte or six-byte surrogate pair)
// becomes the replacement byte from the configuration register (reset '?').
// A malformed or truncated sequence gives a single result with tuser set, tdata
// zero and tlast set, and the rest of that string is dropped up to its tlast
// byte without results. The final result of a string carries tlast. Input
// bytes go into a six-byte lookahead whose head emits at most one result per
// cycle; a result that a byte settles is decided from the lookahead register
// and then presented from the output register. One byte is taken every cycle,
// except that the input is held in each cycle that emits a result leaving
// bytes behind in the lookahead (a prefix that turns out shorter, or several
// characters settled by one byte) or an error result, and is held while a
// decided result waits for the output register to free up.
module modified_utf8_to_ascii
    import mu2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,     // replacement_char
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    input  logic       s_axis_tlast,    // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_char
    output logic       m_axis_tuser,    // [0] is_error
    output logic       m_axis_tlast     // end_of_string
);

    head_t      head;
    logic       out_free;
    logic       pop;
    logic       accept;
    logic       push;
    logic       pop_err;

    logic [7:0] repl_reg;
    logic       discard_reg, discard_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       out_err_reg, out_err_next;
    logic       out_eos_reg, out_eos_next;

    mu2a_lookahead u_lookahead (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_byte (s_axis_tdata),
        .push_last (s_axis_tlast),
        .pop       (pop),
        .head      (head)
    );

    assign out_free = !out_valid_reg || m_axis_tready;
    assign pop      = !discard_reg && (head.cls != CLS_WAIT) && out_free;
    assign pop_err  = pop && (head.cls == CLS_ERR);

    // take a byte only when the lookahead will have nothing left to decide
    assign s_axis_tready = discard_reg || (head.cls == CLS_WAIT)
        || (pop && head.drains && head.cls != CLS_ERR);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign push   = accept && !discard_reg;

    always_comb
    begin
        discard_next = discard_reg;
        if (discard_reg)
        begin
            if (accept && s_axis_tlast)
                discard_next = 1'b0;
        end
        else if (pop_err && !head.at_end)
            discard_next = 1'b1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_err_next   = out_err_reg;
        out_eos_next   = out_eos_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
            out_err_next   = pop_err;
            out_eos_next   = pop_err || (head.at_end && head.drains);
            priority if (pop_err)
                out_char_next = ERR_CHAR;
            else if (head.cls == CLS_ONE)
                out_char_next = head.head_byte;
            else
                out_char_next = repl_reg;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            repl_reg      <= REPL_RESET;
            discard_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                repl_reg <= cfg_wr_data;
            discard_reg   <= discard_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_char_reg <= out_char_next;
        out_err_reg  <= out_err_next;
        out_eos_reg  <= out_eos_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tuser  = out_err_reg;
    assign m_axis_tlast  = out_eos_reg;

    a_err_ends_string: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == ERR_CHAR))
        else $error("error transaction without end of string or with data");

    a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> (head.cls == CLS_WAIT))
        else $error("lookahead holds bytes while discarding");

    a_err_then_discard: assert property (@(posedge clk) disable iff (!rst_n)
        pop_err && !head.at_end |=> discard_reg)
        else $error("error mid-string did not start discarding");

endmodule

// File: rtl/mu2a_lookahead.sv
module mu2a_lookahead
    import mu2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic [7:0] push_byte,
    input  logic       push_last,
    input  logic       pop,
    output head_t      head
);

    la_buf_t buf_reg, buf_next;
    cnt_t    cnt_reg, cnt_next;
    logic    end_reg, end_next;
    cls_t    cls;
    cnt_t    size;

    assign cls  = classify(buf_reg, cnt_reg, end_reg);
    assign size = cls_size(cls);

    assign head.cls       = cls;
    assign head.head_byte = buf_reg[0];
    assign head.drains    = (cls == CLS_ERR) || (size == cnt_reg);
    assign head.at_end    = end_reg;

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        end_next = end_reg;
        if (pop)
        begin
            if (head.drains)
            begin
                cnt_next = '0;
                end_next = 1'b0;
            end
            else
            begin
                // move the rest of the buffer down over the consumed sequence
                unique case (cls)
                    CLS_ONE:
                        for (int i = 0; i < LA_DEPTH - 1; i++)
                            buf_next[i] = buf_reg[i + 1];
                    CLS_TWO:
                        for (int i = 0; i < LA_DEPTH - 2; i++)
                            buf_next[i] = buf_reg[i + 2];
                    CLS_THREE:
                        for (int i = 0; i < LA_DEPTH - 3; i++)
                            buf_next[i] = buf_reg[i + 3];
                    default:
                        buf_next = buf_reg;
                endcase
                cnt_next = cnt_reg - size;
            end
        end
        if (push)
        begin
            buf_next[cnt_next] = push_byte;
            cnt_next           = cnt_next + 3'd1;
            end_next           = push_last;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            end_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            end_reg <= end_next;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'(LA_DEPTH))
        else $error("lookahead count beyond depth");

    a_push_when_settled: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cls == CLS_WAIT) || (pop && head.drains && cls != CLS_ERR))
        else $error("byte pushed while buffered results remain");

    a_end_decides: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg |-> (cnt_reg != 3'd0) && (cls != CLS_WAIT))
        else $error("final byte buffered but head undecided");

endmodule

// File: bench/tb_modified_utf8_to_ascii.sv
`timescale 1ns / 1ps

module tb_modified_utf8_to_ascii
    import mu2a_pkg::*;
();

    typedef struct packed {
        logic [7:0] ch;
        logic       err;
        logic       eos;
    } char_res_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct packed {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        char_res_t  want;
    } probe_t;

    typedef enum int {CH_ASCII, CH_TWO, CH_THREE, CH_PAIR} char_kind_t;
    typedef enum int {BRK_SMASH, BRK_CUT, BRK_EXTRA} break_kind_t;

    localparam char_res_t NO_RES  = '0;
    localparam char_res_t BAD_SEQ = '{ERR_CHAR, 1'b1, 1'b1};
    localparam int        SETTLE_CYCLES = 12;
    localparam int        PHASE_BYTES = 90;

    localparam probe_t PROBES [28] = '{
        '{8'h41, 1'b1, 1'b1, '{8'h41, 1'b0, 1'b1}},
        '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{8'h7F, 1'b1, 1'b1, '{8'h7F, 1'b0, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, BAD_SEQ},
        '{8'h80, 1'b0, 1'b1, BAD_SEQ},
        '{8'h41, 1'b0, 1'b0, NO_RES},
        '{8'h42, 1'b1, 1'b0, NO_RES},
        '{8'hC3, 1'b0, 1'b0, NO_RES},
        '{8'hA9, 1'b1, 1'b1, '{REPL_RESET, 1'b0, 1'b1}},
        '{8'hE2, 1'b0, 1'b0, NO_RES},
        '{8'h82, 1'b0, 1'b0, NO_RES},
        '{8'hAC, 1'b0, 1'b0, NO_RES},
        '{8'hED, 1'b0, 1'b0, NO_RES},
        '{8'hA0, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b0, 1'b0, NO_RES},
        '{8'hED, 1'b0, 1'b0, NO_RES},
        '{8'hB0, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b1, 1'b0, NO_RES},
        '{8'hED, 1'b0, 1'b0, NO_RES},
        '{8'hA5, 1'b0, 1'b0, NO_RES},
        '{8'h81, 1'b1, 1'b0, NO_RES},
        '{8'hE0, 1'b0, 1'b0, NO_RES},
        '{8'h41, 1'b1, 1'b1, BAD_SEQ},
        '{8'hC0, 1'b1, 1'b1, BAD_SEQ},
        '{8'hED, 1'b0, 1'b0, NO_RES},
        '{8'hA0, 1'b0, 1'b0, NO_RES},
        '{8'h80, 1'b0, 1'b0, NO_RES},
        '{8'h41, 1'b1, 1'b0, NO_RES}
    };

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tuser;
    logic       m_axis_tlast;

    // Decoder state mirrored on the bench side
    logic [7:0] repl_byte;
    logic [7:0] la [LA_DEPTH];
    int         la_cnt;
    bit         dropping;

    char_res_t  chars_due [$];
    int         mismatches;
    int         bytes_fed;
    int         strings_sent;
    int         chars_checked;
    int         errors_checked;
    bit         tx_burst;
    bit         rx_burst;

    modified_utf8_to_ascii dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Timeout at %0t", $time);
        $display("Mismatches found");
        $finish;
    end

    function automatic bit cont_byte(input logic [7:0] b);
        return (b & CONT_MASK) == CONT_TAG;
    endfunction

    // Class of the sequence at the head of the lookahead
    function automatic cls_t head_class(input logic fin);
        bit pair_ok;
        bit tri_ok;
        if (!la[0][7])
            return CLS_ONE;
        pair_ok = (la[0] == SURR_LEAD);
        for (int k = 1; k < la_cnt && pair_ok; k++)
        begin
            unique case (k)
                1:       pair_ok = (la[k] & NIBBLE_MASK) == SURR_HI_TAG;
                3:       pair_ok = la[k] == SURR_LEAD;
                4:       pair_ok = (la[k] & NIBBLE_MASK) == SURR_LO_TAG;
                default: pair_ok = cont_byte(la[k]);
            endcase
        end
        if (pair_ok && la_cnt >= LA_DEPTH)
            return CLS_SIX;
        if (pair_ok && !fin)
            return CLS_WAIT;
        tri_ok = ((la[0] & NIBBLE_MASK) == THREE_TAG)
            && (la_cnt < 2 || cont_byte(la[1]))
            && (la_cnt < 3 || cont_byte(la[2]));
        if (tri_ok && la_cnt >= 3)
            return CLS_THREE;
        if (tri_ok && !fin)
            return CLS_WAIT;
        if ((la[0] & TWO_MASK) == TWO_TAG)
        begin
            if (la_cnt >= 2)
                return cont_byte(la[1]) ? CLS_TWO : CLS_ERR;
            return fin ? CLS_ERR : CLS_WAIT;
        end
        return CLS_ERR;
    endfunction

    // Take one byte and return the characters it settles
    function automatic int decode_step(input logic [7:0] b, input logic fin,
                                       output char_res_t res [LA_DEPTH]);
        int   n;
        int   sz;
        cls_t c;
        n = 0;
        for (int k = 0; k < LA_DEPTH; k++)
            res[k] = NO_RES;
        if (dropping)
        begin
            if (fin)
                dropping = 1'b0;
            return 0;
        end
        if (la_cnt < LA_DEPTH)
        begin
            la[la_cnt] = b;
            la_cnt++;
        end
        while (la_cnt > 0 && n < LA_DEPTH)
        begin
            c = head_class(fin);
            if (c == CLS_WAIT)
                break;
            if (c == CLS_ERR)
            begin
                res[n] = BAD_SEQ;
                n++;
                la_cnt = 0;
                if (!fin)
                    dropping = 1'b1;
                return n;
            end
            unique case (c)
                CLS_ONE:   sz = 1;
                CLS_TWO:   sz = 2;
                CLS_THREE: sz = 3;
                default:   sz = LA_DEPTH;
            endcase
            res[n] = '{(c == CLS_ONE) ? la[0] : repl_byte, 1'b0, 1'b0};
            n++;
            for (int k = 0; k + sz < LA_DEPTH; k++)
                la[k] = la[k + sz];
            la_cnt = (sz >= la_cnt) ? 0 : la_cnt - sz;
        end
        if (fin)
        begin
            if (n > 0)
                res[n - 1].eos = 1'b1;
            la_cnt = 0;
        end
        return n;
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic fin, input bit typed,
                             input char_res_t want);
        int        gap;
        int        n;
        char_res_t res [LA_DEPTH];
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge clk); while (!s_axis_tready);
        bytes_fed++;
        n = decode_step(b, fin, res);
        if (typed)
            chars_due.push_back(want);
        else
            for (int k = 0; k < n; k++)
                chars_due.push_back(res[k]);
    endtask

    // Hold the input until every expected character has come out
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (chars_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_repl(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        repl_byte = v;
    endtask

    task automatic send_string();
        logic [7:0]  seq [$];
        int          nch;
        int          pick;
        int          at;
        char_kind_t  kind;
        break_kind_t brk;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 7) == 0)
            tx_burst = !tx_burst;
        if (pick < 15)
        begin
            // raw noise
            nch = $urandom_range(1, 8);
            repeat (nch) seq.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            nch = $urandom_range(1, 10);
            repeat (nch)
            begin
                kind = char_kind_t'($urandom_range(0, 3));
                unique case (kind)
                    CH_ASCII:
                        seq.push_back(8'($urandom_range(0, 127)));
                    CH_TWO:
                    begin
                        seq.push_back(TWO_TAG | 8'($urandom_range(0, 31)));
                        seq.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                    end
                    CH_THREE:
                    begin
                        seq.push_back(THREE_TAG | 8'($urandom_range(0, 15)));
                        seq.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                        seq.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                    end
                    default:
                    begin
                        seq.push_back(SURR_LEAD);
                        seq.push_back(SURR_HI_TAG | 8'($urandom_range(0, 15)));
                        seq.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                        seq.push_back(SURR_LEAD);
                        seq.push_back(SURR_LO_TAG | 8'($urandom_range(0, 15)));
                        seq.push_back(CONT_TAG | 8'($urandom_range(0, 63)));
                    end
                endcase
            end
            if (pick < 30)
            begin
                at  = $urandom_range(0, seq.size() - 1);
                brk = break_kind_t'($urandom_range(0, 2));
                unique case (brk)
                    BRK_SMASH:
                        seq[at] = 8'($urandom_range(0, 255));
                    BRK_CUT:
                        while (seq.size() > at + 1)
                            void'(seq.pop_back());
                    default:
                        seq.insert(at, 8'($urandom_range(0, 255)));
                endcase
            end
        end
        foreach (seq[i])
            push_byte(seq[i], i == seq.size() - 1, 1'b0, NO_RES);
        strings_sent++;
    endtask

    // Sink side: draw a stall for every character, with stall-free stretches
    initial
    begin
        int stall;
        m_axis_tready <= 1'b0;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        char_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (chars_due.size() == 0)
            begin
                $display("%0t: unexpected character ch=%h err=%b eos=%b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end
            else
            begin
                want = chars_due.pop_front();
                chars_checked++;
                if (want.err)
                    errors_checked++;
                if (want.ch !== m_axis_tdata || want.err !== m_axis_tuser
                    || want.eos !== m_axis_tlast)
                begin
                    $display("%0t: expected ch=%h err=%b eos=%b, got ch=%h err=%b eos=%b",
                             $time, want.ch, want.err, want.eos,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        logic [7:0] setting;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        s_axis_tlast  <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 8'h00;
        rst_n         <= 1'b0;
        mismatches     = 0;
        bytes_fed      = 0;
        strings_sent   = 0;
        chars_checked  = 0;
        errors_checked = 0;
        tx_burst       = 1'b0;
        repl_byte      = REPL_RESET;
        la_cnt         = 0;
        dropping       = 1'b0;
        for (int k = 0; k < LA_DEPTH; k++)
            la[k] = 8'h00;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PROBES[i])
            push_byte(PROBES[i].b, PROBES[i].fin, PROBES[i].typed, PROBES[i].want);

        for (int p = 0; p < 4; p++)
        begin
            settle();
            unique case (p)
                0:       setting = 8'h00;
                1:       setting = 8'hFF;
                default: setting = 8'($urandom_range(1, 254));
            endcase
            write_repl(setting);
            begin
                int goal;
                goal = bytes_fed + PHASE_BYTES;
                while (bytes_fed < goal)
                    send_string();
            end
        end
        settle();

        $display("Fed %0d bytes: directed table, %0d random strings, 5 replacement bytes",
                 bytes_fed, strings_sent);
        $display("Checked %0d characters, %0d of them error results", chars_checked,
                 errors_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
